/* hw/rtl/dcpd_pkg.sv */
// ----------------------------------------------------------------------------
// dcpd_pkg
// Shared types and constants of the dictionary code pair decoder.
// ----------------------------------------------------------------------------
package dcpd_pkg;

   localparam int TABLE_DEPTH        = 4096;
   localparam int ADDR_BITS          = $clog2(TABLE_DEPTH);
   localparam int CODE_BITS          = 12;
   localparam int BYTES_WIDTH        = 56;
   localparam int LENGTH_WIDTH       = 3;
   localparam int WORD_SLOTS         = BYTES_WIDTH / 8;
   localparam int DEF_MAX_WORD_BYTES = 7;
   localparam int QUEUE_DEPTH        = 3;
   localparam int QPTR_BITS          = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS        = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic [LENGTH_WIDTH-1:0] length;
      logic [BYTES_WIDTH-1:0]  bytes;
   } word_type;

   typedef struct packed {
      logic                    op;
      logic [ADDR_BITS-1:0]    entry_index;
      logic [BYTES_WIDTH-1:0]  entry_bytes;
      logic [LENGTH_WIDTH-1:0] entry_length;
      logic [2*CODE_BITS-1:0]  code_pair;
      logic                    end_of_block;
   } req_item_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] addr;
      word_type             wdata;
   } ram_req_type;

   typedef struct packed {
      logic pair_last;
      logic block_last;
   } rsp_meta_type;

   typedef struct packed {
      word_type     word;
      rsp_meta_type meta;
   } result_type;

endpackage

/* hw/rtl/dictionary_code_pair_decoder.sv */
// ----------------------------------------------------------------------------
// dictionary_code_pair_decoder
// Variable-to-fixed dictionary decoder with 12-bit codes.
// ----------------------------------------------------------------------------
// A load word (tuser low) writes one of 4096 dictionary entries; bytes at and
// above the length are zeroed and the length is limited to MAX_WORD_BYTES. A
// decode word (tuser high) holds two 12-bit codes and yields two result words,
// low code first; tuser marks the second, and tlast on it repeats the input
// tlast. The dictionary sits in a single-port-read table, so a decode makes
// one table read per result and a load one write. A new input word is taken
// as the current one finishes, and a decode read waits while the result
// queue lacks room. The input word is registered, its read data is registered
// and then queued before it is presented. Entries that were never loaded
// return undefined data, and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module dictionary_code_pair_decoder
   import dcpd_pkg::*;
#(
   parameter int MAX_WORD_BYTES = DEF_MAX_WORD_BYTES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_index[11:0], entry_bytes[67:12], entry_length[70:68],
   // code_pair[94:71], zero [95]
   input  logic [95:0] req_tdata,
   // op
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // word_bytes[55:0], word_length[58:56], zero [63:59]
   output logic [63:0] rsp_tdata,
   // pair_last
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   req_item_type           req_item;
   ram_req_type            ram_req;
   rsp_meta_type           issue_meta;
   rsp_meta_type           rd_meta_ff;
   logic                   rd_valid_ff;
   word_type               rd_word;
   result_type             push_data;
   result_type             pop_data;
   logic [QCOUNT_BITS-1:0] q_count;
   logic                   credit_ok;

   always_comb begin
      req_item.op           = req_tuser;
      req_item.entry_index  = req_tdata[11:0];
      req_item.entry_bytes  = req_tdata[67:12];
      req_item.entry_length = req_tdata[70:68];
      req_item.code_pair    = req_tdata[94:71];
      req_item.end_of_block = req_tlast;
   end

   // Queued results plus the read in flight must leave room for one more.
   assign credit_ok = ({1'b0, q_count} + {{QCOUNT_BITS{1'b0}}, rd_valid_ff})
                    < (QCOUNT_BITS + 1)'(QUEUE_DEPTH);

   dcpd_issue #(
      .MAX_WORD_BYTES(MAX_WORD_BYTES)
   ) u_issue (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .credit_ok  (credit_ok),
      .ram_req    (ram_req),
      .issue_meta (issue_meta)
   );

   dcpd_word_ram u_word_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_word (rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ram_req.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_meta_ff <= issue_meta;
      end
   end

   assign push_data.word = rd_word;
   assign push_data.meta = rd_meta_ff;

   dcpd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rd_valid_ff),
      .push_data (push_data),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (pop_data),
      .count     (q_count)
   );

   assign rsp_tdata = {5'd0, pop_data.word.length, pop_data.word.bytes};
   assign rsp_tuser = pop_data.meta.pair_last;
   assign rsp_tlast = pop_data.meta.block_last;

endmodule

/* hw/rtl/dcpd_word_ram.sv */
// ----------------------------------------------------------------------------
// dcpd_word_ram
// Dictionary storage: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module dcpd_word_ram
   import dcpd_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output word_type    rd_word
);

   word_type word_mem [TABLE_DEPTH];
   word_type rd_word_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         word_mem[ram_req.addr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_word_ff <= word_mem[ram_req.addr];
      end
   end

   assign rd_word = rd_word_ff;

endmodule

/* hw/rtl/dcpd_issue.sv */
// ----------------------------------------------------------------------------
// dcpd_issue
// Holds the current input word and sequences its table accesses: one write
// for a load, two reads (low code, then high code) for a decode.
// ----------------------------------------------------------------------------
module dcpd_issue
   import dcpd_pkg::*;
#(
   parameter int MAX_WORD_BYTES = DEF_MAX_WORD_BYTES
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         credit_ok,
   output ram_req_type  ram_req,
   output rsp_meta_type issue_meta
);

   logic         item_valid_ff, item_valid_in;
   req_item_type item_ff, item_in;
   logic         phase_ff, phase_in;

   logic                    is_decode;
   logic                    issue_fire;
   logic                    item_done;
   logic                    accept;
   logic [LENGTH_WIDTH-1:0] len_sat;
   logic [BYTES_WIDTH-1:0]  bytes_clean;

   assign is_decode  = (item_ff.op == OP_DECODE);
   assign issue_fire = item_valid_ff && (!is_decode || credit_ok);
   assign item_done  = issue_fire && (!is_decode || phase_ff);
   assign req_ready  = !item_valid_ff || item_done;
   assign accept     = req_valid && req_ready;

   // Stored words keep only their valid bytes, so unused positions read zero.
   always_comb begin
      len_sat = (item_ff.entry_length > LENGTH_WIDTH'(MAX_WORD_BYTES))
              ? LENGTH_WIDTH'(MAX_WORD_BYTES) : item_ff.entry_length;
      for (int i = 0; i < WORD_SLOTS; i++) begin
         bytes_clean[i*8 +: 8] = (LENGTH_WIDTH'(i) < len_sat)
                               ? item_ff.entry_bytes[i*8 +: 8] : 8'd0;
      end
   end

   always_comb begin
      ram_req.wr_en        = item_valid_ff && !is_decode;
      ram_req.rd_en        = issue_fire && is_decode;
      ram_req.wdata.bytes  = bytes_clean;
      ram_req.wdata.length = len_sat;
      if (!is_decode) begin
         ram_req.addr = item_ff.entry_index;
      end else if (phase_ff) begin
         ram_req.addr = item_ff.code_pair[2*CODE_BITS-1:CODE_BITS];
      end else begin
         ram_req.addr = item_ff.code_pair[CODE_BITS-1:0];
      end
      issue_meta.pair_last  = phase_ff;
      issue_meta.block_last = phase_ff && item_ff.end_of_block;
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      phase_in      = phase_ff;
      if (issue_fire && is_decode && !phase_ff) begin
         phase_in = 1'b1;
      end
      if (item_done) begin
         item_valid_in = 1'b0;
         phase_in      = 1'b0;
      end
      if (accept) begin
         item_valid_in = 1'b1;
         item_in       = req_item;
         phase_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

/* hw/rtl/dcpd_out_queue.sv */
// ----------------------------------------------------------------------------
// dcpd_out_queue
// Small result queue that decouples table reads from the result channel.
// ----------------------------------------------------------------------------
module dcpd_out_queue
   import dcpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  result_type             push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output result_type             pop_data,
   output logic [QCOUNT_BITS-1:0] count
);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   head_ff, head_in;
   logic [QPTR_BITS-1:0]   tail_ff, tail_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;
   logic                   pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[head_ff];
   assign count     = count_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule
